@@ rtl/tps_pkg.sv @@
package tps_pkg;

    // grid, sampling and image limits
    localparam int GRID_MAX     = 32;
    localparam int SAMPLE_MAX   = 128;
    localparam int SAMPLE_SHIFT = $clog2(SAMPLE_MAX);
    localparam int IMG_DIM_MAX  = 4095;

    // shared unit widths
    localparam int DIV_W     = 12;
    localparam int DIVISOR_W = 6;
    localparam int MUL_W     = 12;

    localparam logic [31:0] HOLD_RESET = 32'd1000000;

    // event codes
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_STEP  = 3'd2;
    localparam logic [2:0] OP_PLAY  = 3'd3;
    localparam logic [2:0] OP_PAUSE = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;
    localparam logic [2:0] OP_FETCH = 3'd6;

    // playback modes
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_READY    = 3'd1;
    localparam logic [2:0] MODE_PLAYING  = 3'd2;
    localparam logic [2:0] MODE_PAUSED   = 3'd3;
    localparam logic [2:0] MODE_COMPLETE = 3'd4;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_DECODE   = 3'd1;
    localparam logic [2:0] STAT_SMALL    = 3'd2;
    localparam logic [2:0] STAT_EMPTY    = 3'd3;
    localparam logic [2:0] STAT_DONE     = 3'd4;
    localparam logic [2:0] STAT_BAD_TILE = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [10:0] pos;
        logic [2:0]  status;
        logic        ok;
    } t_step;

    // clamp a signed grid request to 1..GRID_MAX
    function automatic logic [5:0] clamp_grid(input logic signed [7:0] v);
        logic [5:0] res;
        if (v < 8'sd1) begin
            res = 6'd1;
        end else if (v > 8'(GRID_MAX)) begin
            res = 6'(GRID_MAX);
        end else begin
            res = v[5:0];
        end
        return res;
    endfunction

    // advance one tile
    function automatic t_step do_step(input logic [2:0] mode, input logic [10:0] pos,
                                      input logic [10:0] total, input logic loaded);
        t_step       s;
        logic [10:0] nxt;
        s.mode   = mode;
        s.pos    = pos;
        s.status = STAT_OK;
        s.ok     = 1'b0;
        nxt      = pos + 11'd1;
        if (!loaded || total == 11'd0) begin
            s.status = STAT_EMPTY;
        end else if (pos >= total) begin
            s.mode   = MODE_COMPLETE;
            s.status = STAT_DONE;
        end else begin
            s.pos = nxt;
            s.ok  = 1'b1;
            if (nxt >= total) begin
                s.mode = MODE_COMPLETE;
            end else if (mode != MODE_PLAYING) begin
                s.mode = MODE_READY;
            end
        end
        return s;
    endfunction

endpackage

@@ rtl/tps_div.sv @@
module tps_div
    import tps_pkg::*;
#(
    parameter int DW = DIV_W,
    parameter int VW = DIVISOR_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] n_rem;

    // one restoring step per cycle
    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_div};
        fits    = shifted >= {1'b0, r_div};
        n_rem   = fits ? diff[VW-1:0] : shifted[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DW-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/tps_mul.sv @@
module tps_mul
    import tps_pkg::*;
#(
    parameter int W = MUL_W
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_prod
);

    logic [2*W-1:0] r_prod;

    // registered product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/tile_playback_sequencer.sv @@
// Tile playback sequencer: steps through the tiles of an image grid and maps
// tile sample positions to source pixel addresses.
// Channels: an event input (valid/ready, one event per transfer), a result
// output (valid/ready, exactly one result per event) and a config write
// channel carrying the hold time, always ready and taken in any cycle.
// One event is processed at a time; ready drops for the whole event.
// Reset, step, play, pause and tick go from the execute state straight to the
// result hand-off; a good load adds two passes of the shared restoring
// divider and one of the shared registered multiplier; a good fetch adds
// one divider pass and five multiplier passes.
// A finished result sits in the output register; the next event is taken
// while it waits, but that event's result holds in the sequencer until the
// receiver drains the register, so a stalled receiver stalls the input.
// Synchronous active-low reset: idle mode, nothing loaded, hold time
// 1000000 us, no result pending. No clearing pass is needed.
module tile_playback_sequencer
    import tps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_hold_time,
    // events
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic               i_image_ok,
    input  logic [11:0]        i_image_width,
    input  logic [11:0]        i_image_height,
    input  logic signed [7:0]  i_grid_columns,
    input  logic signed [7:0]  i_grid_rows,
    input  logic [31:0]        i_delta_time,
    input  logic signed [11:0] i_tile_index,
    input  logic [6:0]         i_sample_x,
    input  logic [6:0]         i_sample_y,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_play_state,
    output logic [10:0]        o_current_tile,
    output logic [10:0]        o_tile_count,
    output logic [11:0]        o_tile_width_out,
    output logic [11:0]        o_tile_height_out,
    output logic [2:0]         o_status_code,
    output logic               o_accepted,
    output logic [23:0]        o_pixel_address,
    output logic [7:0]         o_sample_width,
    output logic [7:0]         o_sample_height
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_LDW  = 4'd2;
    localparam logic [3:0] S_LDH  = 4'd3;
    localparam logic [3:0] S_LCHK = 4'd4;
    localparam logic [3:0] S_FDIV = 4'd5;
    localparam logic [3:0] S_FM1  = 4'd6;
    localparam logic [3:0] S_FM2  = 4'd7;
    localparam logic [3:0] S_FM3  = 4'd8;
    localparam logic [3:0] S_FM4  = 4'd9;
    localparam logic [3:0] S_FM5  = 4'd10;
    localparam logic [3:0] S_FM6  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]  r_state;
    logic [31:0] r_hold;

    // captured event
    logic [2:0]  r_op;
    logic        r_img_ok;
    logic [11:0] r_img_w;
    logic [11:0] r_img_h;
    logic [5:0]  r_clamp_c;
    logic [5:0]  r_clamp_r;
    logic [31:0] r_delta;
    logic [11:0] r_idx;
    logic [6:0]  r_sx;
    logic [6:0]  r_sy;

    // sequence state
    logic [2:0]  r_mode;
    logic [10:0] r_pos;
    logic [10:0] r_total;
    logic [5:0]  r_cols;
    logic [5:0]  r_rows;
    logic [11:0] r_tile_w;
    logic [11:0] r_tile_h;
    logic [11:0] r_src_w;
    logic [11:0] r_src_h;
    logic        r_loaded;
    logic [31:0] r_elapsed;

    // per-event results and fetch scratch
    logic [2:0]  r_status;
    logic        r_accepted;
    logic [23:0] r_addr;
    logic [7:0]  r_samp_w;
    logic [7:0]  r_samp_h;
    logic [5:0]  r_col;
    logic [11:0] r_row;
    logic [11:0] r_xoff;
    logic [11:0] r_yoff;
    logic [11:0] r_px;
    logic [11:0] r_py;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_out_mode;
    logic [10:0] r_out_pos;
    logic [10:0] r_out_total;
    logic [11:0] r_out_tile_w;
    logic [11:0] r_out_tile_h;
    logic [2:0]  r_out_status;
    logic        r_out_accepted;
    logic [23:0] r_out_addr;
    logic [7:0]  r_out_samp_w;
    logic [7:0]  r_out_samp_h;

    // shared units
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [DIVISOR_W-1:0]   div_divisor;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;
    logic [DIVISOR_W-1:0]   div_rem;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [2*MUL_W-1:0]     mul_p;

    logic        load_good;
    logic        fetch_loaded;
    logic        fetch_idx_ok;
    logic        capped;
    logic [7:0]  samp_w;
    logic [7:0]  samp_h;
    logic [6:0]  sx_sat;
    logic [6:0]  sy_sat;
    logic [11:0] scaled;
    logic [32:0] tick_sum;
    logic [31:0] tick_sat;
    logic        tick_fire;
    t_step       step_res;

    tps_div #(
        .DW (DIV_W),
        .VW (DIVISOR_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    tps_mul #(
        .W (MUL_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // event checks, sampling geometry and tick arithmetic
    always_comb begin
        load_good = r_img_ok && (r_img_w != 12'd0) && (r_img_h != 12'd0) &&
                    (r_img_w <= 12'(IMG_DIM_MAX)) && (r_img_h <= 12'(IMG_DIM_MAX));
        fetch_loaded = r_loaded && (r_cols != 6'd0);
        fetch_idx_ok = !r_idx[11] && (r_idx[10:0] < r_total);
        capped = (r_tile_w > 12'(SAMPLE_MAX)) || (r_tile_h > 12'(SAMPLE_MAX));
        samp_w = capped ? 8'(SAMPLE_MAX) : r_tile_w[7:0];
        samp_h = capped ? 8'(SAMPLE_MAX) : r_tile_h[7:0];
        sx_sat = ({1'b0, r_sx} >= samp_w) ? 7'(samp_w - 8'd1) : r_sx;
        sy_sat = ({1'b0, r_sy} >= samp_h) ? 7'(samp_h - 8'd1) : r_sy;
        scaled = 12'(mul_p >> SAMPLE_SHIFT);
        tick_sum  = {1'b0, r_elapsed} + {1'b0, r_delta};
        tick_sat  = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
        tick_fire = tick_sat >= r_hold;
        step_res  = do_step(r_mode, r_pos, r_total, r_loaded);
    end

    // divider operand select
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_img_w;
        div_divisor  = r_clamp_c;
        case (r_state)
            S_EXEC: begin
                if (r_op == OP_LOAD && load_good) begin
                    div_start = 1'b1;
                end else if (r_op == OP_FETCH && fetch_loaded && fetch_idx_ok) begin
                    div_start    = 1'b1;
                    div_dividend = r_idx;
                    div_divisor  = r_cols;
                end
            end
            S_LDW: begin
                div_dividend = r_img_h;
                div_divisor  = r_rows;
                div_start    = div_done;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // multiplier operands; product read in the next state (LDW, FDIV: same)
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_LDW: begin
                mul_a = {6'd0, r_cols};
                mul_b = {6'd0, r_rows};
            end
            S_FDIV: begin
                mul_a = {5'd0, sx_sat};
                mul_b = r_tile_w;
            end
            S_FM1: begin
                mul_a = {5'd0, sy_sat};
                mul_b = r_tile_h;
            end
            S_FM2: begin
                mul_a = {6'd0, r_col};
                mul_b = r_tile_w;
            end
            S_FM3: begin
                mul_a = r_row;
                mul_b = r_tile_h;
            end
            S_FM5: begin
                mul_a = r_py;
                mul_b = r_src_w;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hold      <= HOLD_RESET;
            r_mode      <= MODE_IDLE;
            r_pos       <= '0;
            r_total     <= '0;
            r_cols      <= '0;
            r_rows      <= '0;
            r_tile_w    <= '0;
            r_tile_h    <= '0;
            r_src_w     <= '0;
            r_src_h     <= '0;
            r_loaded    <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_hold <= i_cfg_hold_time;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= i_op;
                        r_img_ok  <= i_image_ok;
                        r_img_w   <= i_image_width;
                        r_img_h   <= i_image_height;
                        r_clamp_c <= clamp_grid(i_grid_columns);
                        r_clamp_r <= clamp_grid(i_grid_rows);
                        r_delta   <= i_delta_time;
                        r_idx     <= i_tile_index;
                        r_sx      <= i_sample_x;
                        r_sy      <= i_sample_y;
                        r_state   <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_status   <= STAT_OK;
                    r_accepted <= 1'b0;
                    r_addr     <= '0;
                    r_samp_w   <= '0;
                    r_samp_h   <= '0;
                    r_state    <= S_DONE;
                    case (r_op)
                        OP_LOAD: begin
                            r_mode    <= MODE_IDLE;
                            r_pos     <= '0;
                            r_total   <= '0;
                            r_cols    <= '0;
                            r_rows    <= '0;
                            r_tile_w  <= '0;
                            r_tile_h  <= '0;
                            r_src_w   <= '0;
                            r_src_h   <= '0;
                            r_loaded  <= 1'b0;
                            r_elapsed <= '0;
                            if (!load_good) begin
                                r_status <= STAT_DECODE;
                            end else begin
                                r_cols  <= r_clamp_c;
                                r_rows  <= r_clamp_r;
                                r_state <= S_LDW;
                            end
                        end
                        OP_RESET: begin
                            if (r_loaded) begin
                                r_pos  <= '0;
                                r_mode <= MODE_READY;
                            end else begin
                                r_mode   <= MODE_IDLE;
                                r_pos    <= '0;
                                r_total  <= '0;
                                r_cols   <= '0;
                                r_rows   <= '0;
                                r_tile_w <= '0;
                                r_tile_h <= '0;
                                r_src_w  <= '0;
                                r_src_h  <= '0;
                            end
                            r_elapsed <= '0;
                        end
                        OP_STEP: begin
                            r_mode     <= step_res.mode;
                            r_pos      <= step_res.pos;
                            r_status   <= step_res.status;
                            r_accepted <= step_res.ok;
                        end
                        OP_PLAY: begin
                            if (!r_loaded) begin
                                r_status <= STAT_EMPTY;
                            end else begin
                                if (r_mode == MODE_COMPLETE) begin
                                    r_pos <= '0;
                                end
                                r_mode    <= MODE_PLAYING;
                                r_elapsed <= '0;
                            end
                        end
                        OP_PAUSE: begin
                            if (r_mode == MODE_PLAYING) begin
                                r_mode <= MODE_PAUSED;
                            end
                        end
                        OP_TICK: begin
                            if (r_mode == MODE_PLAYING) begin
                                if (tick_fire) begin
                                    r_elapsed <= '0;
                                    r_mode    <= step_res.mode;
                                    r_pos     <= step_res.pos;
                                    r_status  <= step_res.status;
                                end else begin
                                    r_elapsed <= tick_sat;
                                end
                            end
                        end
                        OP_FETCH: begin
                            if (!fetch_loaded) begin
                                r_status <= STAT_EMPTY;
                            end else if (!fetch_idx_ok) begin
                                r_status <= STAT_BAD_TILE;
                            end else begin
                                r_state <= S_FDIV;
                            end
                        end
                        default: begin
                            r_status <= STAT_OK;
                        end
                    endcase
                end

                // load: tile width, tile count, then tile height
                S_LDW: begin
                    if (div_done) begin
                        r_tile_w <= div_quo;
                        r_total  <= mul_p[10:0];
                        r_state  <= S_LDH;
                    end
                end

                S_LDH: begin
                    if (div_done) begin
                        r_tile_h <= div_quo;
                        r_state  <= S_LCHK;
                    end
                end

                S_LCHK: begin
                    if (r_tile_w == 12'd0 || r_tile_h == 12'd0) begin
                        r_status <= STAT_SMALL;
                    end else begin
                        r_src_w    <= r_img_w;
                        r_src_h    <= r_img_h;
                        r_loaded   <= 1'b1;
                        r_mode     <= MODE_READY;
                        r_accepted <= 1'b1;
                    end
                    r_state <= S_DONE;
                end

                // fetch: tile row and column, then offsets and address
                S_FDIV: begin
                    if (div_done) begin
                        r_col   <= div_rem;
                        r_row   <= div_quo;
                        r_xoff  <= capped ? scaled : {5'd0, sx_sat};
                        r_state <= S_FM1;
                    end
                end

                S_FM1: begin
                    r_state <= S_FM2;
                end

                S_FM2: begin
                    r_yoff  <= capped ? scaled : {5'd0, sy_sat};
                    r_state <= S_FM3;
                end

                S_FM3: begin
                    r_px    <= mul_p[11:0] + r_xoff;
                    r_state <= S_FM4;
                end

                S_FM4: begin
                    r_py    <= mul_p[11:0] + r_yoff;
                    r_state <= S_FM5;
                end

                S_FM5: begin
                    r_state <= S_FM6;
                end

                S_FM6: begin
                    r_addr     <= mul_p + {12'd0, r_px};
                    r_accepted <= 1'b1;
                    r_samp_w   <= samp_w;
                    r_samp_h   <= samp_h;
                    r_state    <= S_DONE;
                end

                // hand the result to the output register once it is free
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_mode     <= r_mode;
                        r_out_pos      <= r_pos;
                        r_out_total    <= r_total;
                        r_out_tile_w   <= r_tile_w;
                        r_out_tile_h   <= r_tile_h;
                        r_out_status   <= r_status;
                        r_out_accepted <= r_accepted;
                        r_out_addr     <= r_addr;
                        r_out_samp_w   <= r_samp_w;
                        r_out_samp_h   <= r_samp_h;
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_play_state      = r_out_mode;
    assign o_current_tile    = r_out_pos;
    assign o_tile_count      = r_out_total;
    assign o_tile_width_out  = r_out_tile_w;
    assign o_tile_height_out = r_out_tile_h;
    assign o_status_code     = r_out_status;
    assign o_accepted        = r_out_accepted;
    assign o_pixel_address   = r_out_addr;
    assign o_sample_width    = r_out_samp_w;
    assign o_sample_height   = r_out_samp_h;

endmodule

@@ rtl/tps_chk.sv @@
module tps_chk
    import tps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_accepted,
    input logic [2:0]  o_status_code,
    input logic [23:0] o_pixel_address,
    input logic [7:0]  o_sample_width,
    input logic [10:0] o_current_tile,
    input logic [10:0] o_tile_count
);

    // a pending result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // one event at a time: ready drops after each input transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // a successful event always reports ok status
    a_accept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_status_code == STAT_OK)
        else $error("accepted event with error status");

    // fetch fields stay zero unless the event succeeded
    a_fetch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_pixel_address == 24'd0 && o_sample_width == 8'd0)
        else $error("fetch fields set on rejected event");

    // playback position never runs past the tile count
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_current_tile <= o_tile_count)
        else $error("current tile beyond tile count");

endmodule

bind tile_playback_sequencer tps_chk u_tps_chk (.*);
